FILE: hw/rtl/fdca_pkg.sv
// ----------------------------------------------------------------------------
// fdca_pkg
// shared types, constants and helpers of the frame difference averager
// ----------------------------------------------------------------------------
package fdca_pkg;

  localparam int PIX_W        = 8;
  localparam int MEAN_W       = 16;
  localparam int FRAME_W      = 16;
  localparam int CFG_W        = 10;
  localparam int NUM_CH       = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = 2;
  localparam int QUEUE_FILL_W = 3;

  localparam logic [CFG_W-1:0]   ROWS_RESET  = 10'd480;
  localparam logic [CFG_W-1:0]   COLS_RESET  = 10'd512;
  localparam logic [FRAME_W-1:0] FRAME_FIRST = 16'd1;

  // register index, taken from the word address
  localparam logic REG_FRAME_ROWS = 1'b0;
  localparam logic REG_FRAME_COLS = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic               last;
    logic               have_prev;
    logic [FRAME_W-1:0] frame_no;
  } tag_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

FILE: hw/rtl/fdca_ram.sv
// ----------------------------------------------------------------------------
// fdca_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fdca_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fdca_front.sv
// ----------------------------------------------------------------------------
// fdca_front
// accepts pixels, tracks raster position and frame count, marks frame ends
// ----------------------------------------------------------------------------
module fdca_front #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512,
  parameter int ROW_W    = $clog2(MAX_ROWS + 1),
  parameter int COL_W    = $clog2(MAX_COLS + 1),
  parameter int CNT_W    = $clog2(MAX_ROWS * MAX_COLS + 1),
  parameter int POS_W    = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fdca_pkg::CFG_W-1:0] frame_rows,
  input  logic [fdca_pkg::CFG_W-1:0] frame_cols,
  input  logic                       in_valid,
  input  fdca_pkg::pixel_t           in_pix,
  output logic                       in_ready,
  input  logic                       q_full,
  output logic                       push,
  output fdca_pkg::pixel_t           pix,
  output fdca_pkg::tag_t             tag,
  output logic [POS_W-1:0]           pos,
  output logic [CNT_W-1:0]           count
);

  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic                             have_prev_r, have_prev_nxt;
  logic [fdca_pkg::FRAME_W-1:0]     frame_r, frame_nxt;
  logic [ROW_W-1:0]                 rows;
  logic [COL_W-1:0]                 cols;
  logic                             last;

  // size clamp
  always_comb begin
    if (frame_rows == '0) begin
      rows = ROW_W'(1);
    end else if (32'(frame_rows) > 32'(MAX_ROWS)) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = ROW_W'(frame_rows);
    end
    if (frame_cols == '0) begin
      cols = COL_W'(1);
    end else if (32'(frame_cols) > 32'(MAX_COLS)) begin
      cols = COL_W'(MAX_COLS);
    end else begin
      cols = COL_W'(frame_cols);
    end
  end

  assign count = CNT_W'(rows) * CNT_W'(cols);
  assign last  = ((CNT_W+1)'(pos_r) + (CNT_W+1)'(1)) >= (CNT_W+1)'(count);

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign pix      = in_pix;
  assign pos      = pos_r;

  always_comb begin
    tag.last      = last;
    tag.have_prev = have_prev_r;
    tag.frame_no  = frame_r;
  end

  always_comb begin
    pos_nxt       = pos_r;
    have_prev_nxt = have_prev_r;
    frame_nxt     = frame_r;
    if (push) begin
      if (last) begin
        pos_nxt       = '0;
        have_prev_nxt = 1'b1;
        frame_nxt     = frame_r + fdca_pkg::FRAME_W'(1);
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      have_prev_r <= 1'b0;
      frame_r     <= fdca_pkg::FRAME_FIRST;
    end else begin
      pos_r       <= pos_nxt;
      have_prev_r <= have_prev_nxt;
      frame_r     <= frame_nxt;
    end
  end

endmodule

FILE: hw/rtl/fdca_queue.sv
// ----------------------------------------------------------------------------
// fdca_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module fdca_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  logic [WIDTH-1:0]                     mem_r [fdca_pkg::QUEUE_DEPTH];
  logic [fdca_pkg::QUEUE_AW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [fdca_pkg::QUEUE_FILL_W-1:0]    fill_r, fill_nxt;

  assign full  = (fill_r == fdca_pkg::QUEUE_FILL_W'(fdca_pkg::QUEUE_DEPTH));
  assign valid = (fill_r != '0);
  assign data  = mem_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + fdca_pkg::QUEUE_FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - fdca_pkg::QUEUE_FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + fdca_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + fdca_pkg::QUEUE_AW'(1);
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: hw/rtl/fdca_div.sv
// ----------------------------------------------------------------------------
// fdca_div
// three restoring dividers, one quotient bit per cycle, holding the result
// ----------------------------------------------------------------------------
module fdca_div #(
  parameter int CNT_W = 19,
  parameter int SUM_W = 26
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [SUM_W-1:0]             sum    [fdca_pkg::NUM_CH],
  input  logic [CNT_W-1:0]             count,
  input  logic [fdca_pkg::FRAME_W-1:0] frame_no,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fdca_pkg::MEAN_W-1:0]  mean   [fdca_pkg::NUM_CH],
  output logic [fdca_pkg::FRAME_W-1:0] out_frame_no
);

  // dividend is the sum with eight fraction bits appended
  localparam int DVD_W  = SUM_W + 8;
  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  fdca_pkg::div_state_t                state_r, state_nxt;
  logic [STEP_W-1:0]                   step_r;
  logic [CNT_W-1:0]                    cnt_r;
  logic [fdca_pkg::FRAME_W-1:0]        fno_r;
  logic [CNT_W-1:0]                    rem_r   [fdca_pkg::NUM_CH];
  logic [CNT_W-1:0]                    rem_nxt [fdca_pkg::NUM_CH];
  logic [DVD_W-1:0]                    shf_r   [fdca_pkg::NUM_CH];
  logic [CNT_W:0]                      trial   [fdca_pkg::NUM_CH];
  logic                                qbit    [fdca_pkg::NUM_CH];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fdca_pkg::DIV_IDLE: begin
        if (start) state_nxt = fdca_pkg::DIV_RUN;
      end
      fdca_pkg::DIV_RUN: begin
        if (step_r == LAST_STEP) state_nxt = fdca_pkg::DIV_DONE;
      end
      fdca_pkg::DIV_DONE: begin
        if (out_ready) state_nxt = fdca_pkg::DIV_IDLE;
      end
      default: state_nxt = fdca_pkg::DIV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      fdca_pkg::DIV_IDLE: busy = 1'b0;
      fdca_pkg::DIV_RUN:  busy = 1'b1;
      fdca_pkg::DIV_DONE: out_valid = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  // one quotient bit per lane
  always_comb begin
    for (int l = 0; l < fdca_pkg::NUM_CH; l++) begin
      trial[l] = {rem_r[l], shf_r[l][DVD_W-1]};
      qbit[l]  = (trial[l] >= {1'b0, cnt_r});
      if (qbit[l]) begin
        rem_nxt[l] = CNT_W'(trial[l] - {1'b0, cnt_r});
      end else begin
        rem_nxt[l] = CNT_W'(trial[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= count;
      fno_r <= frame_no;
      for (int l = 0; l < fdca_pkg::NUM_CH; l++) begin
        rem_r[l] <= '0;
        shf_r[l] <= {sum[l], 8'h00};
      end
    end else if (state_r == fdca_pkg::DIV_RUN) begin
      for (int l = 0; l < fdca_pkg::NUM_CH; l++) begin
        rem_r[l] <= rem_nxt[l];
        shf_r[l] <= {shf_r[l][DVD_W-2:0], qbit[l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdca_pkg::DIV_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        step_r <= '0;
      end else if (state_r == fdca_pkg::DIV_RUN) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // low quotient bits, wrapping like the output field
  always_comb begin
    for (int l = 0; l < fdca_pkg::NUM_CH; l++) begin
      mean[l] = shf_r[l][fdca_pkg::MEAN_W-1:0];
    end
  end

  assign out_frame_no = fno_r;

endmodule

FILE: hw/rtl/fdca_back.sv
// ----------------------------------------------------------------------------
// fdca_back
// frame store read, absolute difference sums, store update, divider launch
// ----------------------------------------------------------------------------
module fdca_back #(
  parameter int DEPTH = 262144,
  parameter int CNT_W = 19,
  parameter int SUM_W = 26,
  parameter int POS_W = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  fdca_pkg::pixel_t             q_pix,
  input  fdca_pkg::tag_t               q_tag,
  input  logic [POS_W-1:0]             q_pos,
  input  logic [CNT_W-1:0]             q_count,
  output logic                         q_pop,
  input  logic                         div_busy,
  output logic                         div_start,
  output logic [SUM_W-1:0]             div_sum [fdca_pkg::NUM_CH],
  output logic [CNT_W-1:0]             div_count,
  output logic [fdca_pkg::FRAME_W-1:0] div_frame_no
);

  logic                        s1_valid_r;
  fdca_pkg::pixel_t            s1_pix_r;
  fdca_pkg::tag_t              s1_tag_r;
  logic [POS_W-1:0]            s1_pos_r;
  logic [CNT_W-1:0]            s1_count_r;
  logic                        fwd_r;
  fdca_pkg::pixel_t            fwd_pix_r;
  logic [$bits(fdca_pkg::pixel_t)-1:0] rdata;
  fdca_pkg::pixel_t            old_pix;
  logic [fdca_pkg::PIX_W-1:0]  diff    [fdca_pkg::NUM_CH];
  logic [SUM_W-1:0]            sum_r   [fdca_pkg::NUM_CH];
  logic [SUM_W-1:0]            sum_nxt [fdca_pkg::NUM_CH];
  logic [SUM_W-1:0]            sum_acc [fdca_pkg::NUM_CH];

  fdca_ram #(
    .WIDTH ($bits(fdca_pkg::pixel_t)),
    .DEPTH (DEPTH),
    .AW    (POS_W)
  ) u_store (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_pos_r),
    .wdata (s1_pix_r),
    .re    (q_pop),
    .raddr (q_pos),
    .rdata (rdata)
  );

  assign div_start = s1_valid_r && s1_tag_r.last && s1_tag_r.have_prev;
  assign q_pop     = q_valid &&
                     !(q_tag.last && q_tag.have_prev && (div_busy || div_start));

  // same position written in the cycle of its read
  assign old_pix = fwd_r ? fwd_pix_r : fdca_pkg::pixel_t'(rdata);

  always_comb begin
    diff[0] = fdca_pkg::abs_diff(s1_pix_r.red,   old_pix.red);
    diff[1] = fdca_pkg::abs_diff(s1_pix_r.green, old_pix.green);
    diff[2] = fdca_pkg::abs_diff(s1_pix_r.blue,  old_pix.blue);
    for (int l = 0; l < fdca_pkg::NUM_CH; l++) begin
      sum_acc[l] = sum_r[l] + SUM_W'(diff[l]);
      sum_nxt[l] = sum_r[l];
      if (s1_valid_r) begin
        if (s1_tag_r.last) begin
          sum_nxt[l] = '0;
        end else if (s1_tag_r.have_prev) begin
          sum_nxt[l] = sum_acc[l];
        end
      end
    end
  end

  assign div_sum      = sum_acc;
  assign div_count    = s1_count_r;
  assign div_frame_no = s1_tag_r.frame_no;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_pix_r   <= q_pix;
      s1_tag_r   <= q_tag;
      s1_pos_r   <= q_pos;
      s1_count_r <= q_count;
    end
    fwd_pix_r <= s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      for (int l = 0; l < fdca_pkg::NUM_CH; l++) begin
        sum_r[l] <= '0;
      end
    end else begin
      s1_valid_r <= q_pop;
      fwd_r      <= q_pop && s1_valid_r && (s1_pos_r == q_pos);
      sum_r      <= sum_nxt;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_tag_r.last) |=>
      (sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0))
    else $error("sums not cleared after frame end");

  a_pop_stage: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_valid_r)
    else $error("popped item missing from stage");

  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> ($past(s1_valid_r) && $past(s1_pos_r) == s1_pos_r))
    else $error("forward without matching write");

endmodule

FILE: hw/rtl/frame_diff_channel_average_core.sv
// ----------------------------------------------------------------------------
// frame_diff_channel_average_core
// per-channel mean absolute difference between successive video frames
// ----------------------------------------------------------------------------
// Takes one pixel per clock in steady state. A pixel is accepted into a
// four-entry queue; the back end reads the previous frame's pixel from the
// frame store (registered read), adds the channel differences and writes
// the new pixel back from its stage register once the pixel has left the
// queue. At the last pixel of each frame after the first, the three 8.8
// means are produced by restoring dividers running side by side, one
// quotient bit per cycle over the whole dividend (the channel sum with eight
// fraction bits, 34 bits for the default 512 by 512 store): the result is
// held until taken. Pixel flow continues during division; only the next
// frame end waits for the divider and the output register. The frame store
// needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module frame_diff_channel_average_core #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_red,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red_mean_diff,
  output logic [15:0] out_green_mean_diff,
  output logic [15:0] out_blue_mean_diff,
  output logic [15:0] out_frame_number
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int COL_W = $clog2(MAX_COLS + 1);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = $clog2(64'(255) * 64'(DEPTH) + 64'd1);
  localparam int QW    = $bits(fdca_pkg::pixel_t) + $bits(fdca_pkg::tag_t) + POS_W + CNT_W;

  logic [fdca_pkg::CFG_W-1:0]  frame_rows_r;
  logic [fdca_pkg::CFG_W-1:0]  frame_cols_r;
  logic                        cfg_write;

  fdca_pkg::pixel_t            in_pix;
  logic                        push;
  fdca_pkg::pixel_t            f_pix;
  fdca_pkg::tag_t              f_tag;
  logic [POS_W-1:0]            f_pos;
  logic [CNT_W-1:0]            f_count;
  logic                        q_full;
  logic                        q_valid;
  logic                        q_pop;
  logic [QW-1:0]               q_data;
  fdca_pkg::pixel_t            q_pix;
  fdca_pkg::tag_t              q_tag;
  logic [POS_W-1:0]            q_pos;
  logic [CNT_W-1:0]            q_count;

  logic                        div_busy;
  logic                        div_start;
  logic [SUM_W-1:0]            div_sum [fdca_pkg::NUM_CH];
  logic [CNT_W-1:0]            div_count;
  logic [fdca_pkg::FRAME_W-1:0] div_frame_no;
  logic [fdca_pkg::MEAN_W-1:0] mean [fdca_pkg::NUM_CH];

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= fdca_pkg::ROWS_RESET;
      frame_cols_r <= fdca_pkg::COLS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        fdca_pkg::REG_FRAME_ROWS: frame_rows_r <= pwdata[fdca_pkg::CFG_W-1:0];
        fdca_pkg::REG_FRAME_COLS: frame_cols_r <= pwdata[fdca_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fdca_pkg::REG_FRAME_ROWS: prdata = 32'(frame_rows_r);
      fdca_pkg::REG_FRAME_COLS: prdata = 32'(frame_cols_r);
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    in_pix.red   = in_pixel_red;
    in_pix.green = in_pixel_green;
    in_pix.blue  = in_pixel_blue;
  end

  fdca_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W),
    .CNT_W    (CNT_W),
    .POS_W    (POS_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_rows (frame_rows_r),
    .frame_cols (frame_cols_r),
    .in_valid   (in_valid),
    .in_pix     (in_pix),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .pix        (f_pix),
    .tag        (f_tag),
    .pos        (f_pos),
    .count      (f_count)
  );

  fdca_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_pix, f_tag, f_pos, f_count}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  assign {q_pix, q_tag, q_pos, q_count} = q_data;

  fdca_back #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .POS_W (POS_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_pix        (q_pix),
    .q_tag        (q_tag),
    .q_pos        (q_pos),
    .q_count      (q_count),
    .q_pop        (q_pop),
    .div_busy     (div_busy),
    .div_start    (div_start),
    .div_sum      (div_sum),
    .div_count    (div_count),
    .div_frame_no (div_frame_no)
  );

  fdca_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (div_start),
    .sum          (div_sum),
    .count        (div_count),
    .frame_no     (div_frame_no),
    .busy         (div_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mean         (mean),
    .out_frame_no (out_frame_number)
  );

  assign out_red_mean_diff   = mean[0];
  assign out_green_mean_diff = mean[1];
  assign out_blue_mean_diff  = mean[2];

endmodule
